@@ src/mdus_pkg.sv @@
// ----------------------------------------------------------------------------
// mdus_pkg: shared types and constants for the update sequencer
// Command, phase, fault and register index codes, plus the slot lookup.
// ----------------------------------------------------------------------------
package mdus_pkg;

  typedef enum logic [2:0] {
    CMD_INIT      = 3'd0,
    CMD_BEGIN     = 3'd1,
    CMD_STAGE     = 3'd2,
    CMD_VERIFY    = 3'd3,
    CMD_ACTIVATE  = 3'd4,
    CMD_SELF_TEST = 3'd5,
    CMD_COMMIT    = 3'd6,
    CMD_DL_CHECK  = 3'd7
  } cmd_t;

  // Update phase; the codes are visible on the result channel.
  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_STAGING    = 3'd1,
    PH_VERIFIED   = 3'd2,
    PH_ACTIVATING = 3'd3,
    PH_COMMITTED  = 3'd4,
    PH_ROLLED     = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    FLT_NONE       = 3'd0,
    FLT_PRECOND    = 3'd1,
    FLT_INCOMPLETE = 3'd2,
    FLT_VERIFY     = 3'd3,
    FLT_ORDER      = 3'd4,
    FLT_SELF_TEST  = 3'd5,
    FLT_DEADLINE   = 3'd6
  } fault_t;

  localparam logic CFG_DEADLINE = 1'b0;
  localparam logic CFG_ORDER    = 1'b1;

  localparam logic [31:0] DEADLINE_RST = 32'd60000;
  localparam logic [14:0] ORDER_RST    = 15'd18056;

  // Domain id expected in a given activation slot; slots past the table read 0.
  function automatic logic [2:0] order_slot(input logic [14:0] tbl, input logic [3:0] slot);
    logic [2:0] id;
    case (slot)
      4'd0:    id = tbl[2:0];
      4'd1:    id = tbl[5:3];
      4'd2:    id = tbl[8:6];
      4'd3:    id = tbl[11:9];
      4'd4:    id = tbl[14:12];
      default: id = 3'd0;
    endcase
    return id;
  endfunction

endpackage

@@ src/multi_domain_update_sequencer.sv @@
// ----------------------------------------------------------------------------
// multi_domain_update_sequencer: firmware update sequencer over several domains
// Takes one command item at a time, updates the per-domain build and flag
// registers, and returns one status item per command.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake             | Payload
//  ---------+-----------+-----------------------+-----------------------------------
//  in_      | input     | in_valid / in_ready   | cmd, domain, build, condition
//           |           |                       | bits, now_time
//  out_     | output    | out_valid / out_ready | ok, phase_now, fault_now,
//           |           |                       | next_slot, domain_build
//  cfg_     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Each item is captured in the input register and is resolved by
// combinational logic into the output register, which presents the result.
// One item per cycle is sustained while out_ready is held high; the input
// register and the output register both hold when the result side stalls,
// so ready falls only when both are full.
// Reset is synchronous and active low; it restores the default deadline and
// order table and clears every build id, flag and the phase and fault.
// Configuration writes are always accepted (cfg_ready is tied high).

module multi_domain_update_sequencer
  import mdus_pkg::*;
#(
  parameter int DOMAINS = 5
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_cmd,
  input  logic [2:0]  in_domain,
  input  logic [31:0] in_build,
  input  logic        in_readback_ok,
  input  logic        in_self_test_ok,
  input  logic        in_kill_engaged,
  input  logic        in_tx_quiet,
  input  logic        in_power_stable,
  input  logic        in_proto_compatible,
  input  logic [31:0] in_now_time,

  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_ok,
  output logic [2:0]  out_phase_now,
  output logic [2:0]  out_fault_now,
  output logic [3:0]  out_next_slot,
  output logic [31:0] out_domain_build,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int DW = (DOMAINS > 1) ? $clog2(DOMAINS) : 1;
  localparam logic [DOMAINS-1:0] ALL_MASK = {DOMAINS{1'b1}};
  localparam logic [3:0] DOM_CNT = 4'(DOMAINS);

  // Configuration registers.
  logic [31:0] deadline_r;
  logic [14:0] order_r;

  // Input register.
  logic        in_vld_r;
  cmd_t        cmd_r;
  logic [2:0]  dom_r;
  logic [31:0] build_r;
  logic        readback_r;
  logic        st_ok_r;
  logic        conds_r;
  logic [31:0] now_r;

  // Sequencer state.
  logic [31:0] act_r  [DOMAINS];
  logic [31:0] prev_r [DOMAINS];
  logic [31:0] pend_r [DOMAINS];
  logic [31:0] act_nxt  [DOMAINS];
  logic [31:0] prev_nxt [DOMAINS];
  logic [31:0] pend_nxt [DOMAINS];
  logic [DOMAINS-1:0] staged_r, staged_nxt;
  logic [DOMAINS-1:0] verified_r, verified_nxt;
  logic [DOMAINS-1:0] activated_r, activated_nxt;
  logic [DOMAINS-1:0] selftest_r, selftest_nxt;
  logic [31:0] start_r, start_nxt;
  logic [3:0]  slot_r, slot_nxt;
  phase_t      phase_r, phase_nxt;
  fault_t      fault_r, fault_nxt;

  // Output register.
  logic        out_vld_r;
  logic        ok_r, ok_nxt;
  logic [31:0] dbuild_r, dbuild_nxt;

  logic              fire;
  logic              in_range;
  logic [DW-1:0]     d_idx;
  logic [DOMAINS-1:0] bit_v;
  logic              dl_fail;
  logic              rb;
  fault_t            rb_fault;

  // An item in the input register resolves whenever the output register is
  // free or is being emptied in the same cycle.
  assign fire      = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || fire;
  assign cfg_ready = 1'b1;

  assign in_range = ({1'b0, dom_r} < DOM_CNT);
  assign d_idx    = dom_r[DW-1:0];

  always_comb begin
    for (int i = 0; i < DOMAINS; i++) begin
      bit_v[i] = ({1'b0, dom_r} == 4'(i));
    end
  end

  // The deadline only runs while an update is in flight (staging, verified
  // or activating); elapsed time is taken modulo 2^32.
  assign dl_fail = ((phase_r == PH_STAGING) || (phase_r == PH_VERIFIED) ||
                    (phase_r == PH_ACTIVATING)) &&
                   ((now_r - start_r) > deadline_r);

  // Command decode. At most one rollback can happen per command; it is
  // flagged here and applied after the command arm.
  always_comb begin
    act_nxt       = act_r;
    prev_nxt      = prev_r;
    pend_nxt      = pend_r;
    staged_nxt    = staged_r;
    verified_nxt  = verified_r;
    activated_nxt = activated_r;
    selftest_nxt  = selftest_r;
    start_nxt     = start_r;
    slot_nxt      = slot_r;
    phase_nxt     = phase_r;
    fault_nxt     = fault_r;
    ok_nxt        = 1'b0;
    rb            = 1'b0;
    rb_fault      = FLT_NONE;

    unique case (cmd_r)
      CMD_INIT: begin
        for (int i = 0; i < DOMAINS; i++) begin
          act_nxt[i]  = build_r;
          prev_nxt[i] = build_r;
          pend_nxt[i] = '0;
        end
        staged_nxt    = '0;
        verified_nxt  = '0;
        activated_nxt = '0;
        selftest_nxt  = '0;
        start_nxt     = '0;
        slot_nxt      = '0;
        phase_nxt     = PH_IDLE;
        fault_nxt     = FLT_NONE;
        ok_nxt        = 1'b1;
      end
      CMD_BEGIN: begin
        if (!conds_r) begin
          fault_nxt = FLT_PRECOND;
        end else begin
          for (int i = 0; i < DOMAINS; i++) begin
            prev_nxt[i] = act_r[i];
            pend_nxt[i] = '0;
          end
          staged_nxt    = '0;
          verified_nxt  = '0;
          activated_nxt = '0;
          selftest_nxt  = '0;
          start_nxt     = now_r;
          slot_nxt      = '0;
          phase_nxt     = PH_STAGING;
          fault_nxt     = FLT_NONE;
          ok_nxt        = 1'b1;
        end
      end
      CMD_STAGE: begin
        if (!readback_r) begin
          // A failed read-back rolls back in any phase.
          rb       = 1'b1;
          rb_fault = FLT_VERIFY;
        end else if (phase_r == PH_STAGING && in_range && build_r != '0) begin
          pend_nxt[d_idx] = build_r;
          staged_nxt      = staged_r | bit_v;
          verified_nxt    = verified_r | bit_v;
          ok_nxt          = 1'b1;
        end
      end
      CMD_VERIFY: begin
        if (phase_r == PH_STAGING) begin
          if ((staged_r & verified_r) != ALL_MASK) begin
            fault_nxt = FLT_INCOMPLETE;
          end else begin
            phase_nxt = PH_VERIFIED;
            ok_nxt    = 1'b1;
          end
        end
      end
      CMD_ACTIVATE: begin
        if (dl_fail) begin
          rb       = 1'b1;
          rb_fault = FLT_DEADLINE;
        end else if ((phase_r != PH_VERIFIED && phase_r != PH_ACTIVATING) ||
                     slot_r >= DOM_CNT || !in_range ||
                     order_slot(order_r, slot_r) != dom_r) begin
          if (phase_r != PH_ROLLED) begin
            rb       = 1'b1;
            rb_fault = FLT_ORDER;
          end
        end else begin
          act_nxt[d_idx] = pend_r[d_idx];
          activated_nxt  = activated_r | bit_v;
          slot_nxt       = slot_r + 4'd1;
          phase_nxt      = PH_ACTIVATING;
          ok_nxt         = 1'b1;
        end
      end
      CMD_SELF_TEST: begin
        if (phase_r == PH_ACTIVATING && in_range && (activated_r & bit_v) != '0) begin
          if (!st_ok_r) begin
            rb       = 1'b1;
            rb_fault = FLT_SELF_TEST;
          end else begin
            selftest_nxt = selftest_r | bit_v;
            ok_nxt       = 1'b1;
          end
        end
      end
      CMD_COMMIT: begin
        if (dl_fail) begin
          rb       = 1'b1;
          rb_fault = FLT_DEADLINE;
        end else if (phase_r == PH_ACTIVATING && slot_r == DOM_CNT &&
                     (activated_r & selftest_r) == ALL_MASK) begin
          phase_nxt = PH_COMMITTED;
          ok_nxt    = 1'b1;
        end
      end
      CMD_DL_CHECK: begin
        if (dl_fail) begin
          rb       = 1'b1;
          rb_fault = FLT_DEADLINE;
        end else begin
          ok_nxt = 1'b1;
        end
      end
      default: begin
        ok_nxt = 1'b0;
      end
    endcase

    // Rollback restores the previous builds and keeps only the first fault.
    if (rb) begin
      if (fault_r == FLT_NONE) begin
        fault_nxt = rb_fault;
      end
      act_nxt       = prev_r;
      activated_nxt = '0;
      selftest_nxt  = '0;
      phase_nxt     = PH_ROLLED;
    end

    dbuild_nxt = in_range ? act_nxt[d_idx] : '0;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadline_r <= DEADLINE_RST;
      order_r    <= ORDER_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_DEADLINE) begin
        deadline_r <= cfg_data;
      end else begin
        order_r <= cfg_data[14:0];
      end
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r      <= cmd_t'(in_cmd);
      dom_r      <= in_domain;
      build_r    <= in_build;
      readback_r <= in_readback_ok;
      st_ok_r    <= in_self_test_ok;
      conds_r    <= in_kill_engaged && in_tx_quiet && in_power_stable && in_proto_compatible;
      now_r      <= in_now_time;
    end
  end

  // Sequencer state; reset clears the build ids as well.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DOMAINS; i++) begin
        act_r[i]  <= '0;
        prev_r[i] <= '0;
        pend_r[i] <= '0;
      end
      staged_r    <= '0;
      verified_r  <= '0;
      activated_r <= '0;
      selftest_r  <= '0;
      start_r     <= '0;
      slot_r      <= '0;
      phase_r     <= PH_IDLE;
      fault_r     <= FLT_NONE;
    end else if (fire) begin
      act_r       <= act_nxt;
      prev_r      <= prev_nxt;
      pend_r      <= pend_nxt;
      staged_r    <= staged_nxt;
      verified_r  <= verified_nxt;
      activated_r <= activated_nxt;
      selftest_r  <= selftest_nxt;
      start_r     <= start_nxt;
      slot_r      <= slot_nxt;
      phase_r     <= phase_nxt;
      fault_r     <= fault_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  logic [2:0] phase_o_r;
  logic [2:0] fault_o_r;
  logic [3:0] slot_o_r;

  always_ff @(posedge clk) begin
    if (fire) begin
      ok_r      <= ok_nxt;
      phase_o_r <= phase_nxt;
      fault_o_r <= fault_nxt;
      slot_o_r  <= slot_nxt;
      dbuild_r  <= dbuild_nxt;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_ok           = ok_r;
  assign out_phase_now    = phase_o_r;
  assign out_fault_now    = fault_o_r;
  assign out_next_slot    = slot_o_r;
  assign out_domain_build = dbuild_r;

  // The slot counter never passes the number of domains.
  a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= DOM_CNT)
    else $error("slot index beyond domain count");

  // Idle means no activation has happened since init or reset.
  a_idle_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (slot_r == '0 && activated_r == '0))
    else $error("idle phase with activation state");

  // A committed update has gone through every slot.
  a_commit_slots: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_COMMITTED) |-> (slot_r == DOM_CNT))
    else $error("committed before all slots activated");

  // A domain can only be activated after every domain was staged.
  a_act_staged: assert property (@(posedge clk) disable iff (!rst_n)
    (activated_r != '0) |-> (staged_r == ALL_MASK))
    else $error("activation without full staging");

  // A result waiting on a stalled output is not overwritten.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_ready) |=> (out_vld_r && $stable(dbuild_r) && $stable(ok_r)))
    else $error("stalled result changed");

endmodule
